>>> design/qfx_pkg.sv
// Package with the shared opcodes, constants and pipeline payload types of the fixed-point ALU.
`default_nettype none
package qfx_pkg;

  localparam int unsigned DefFractionBits = 48;
  localparam int unsigned DivSteps        = 128;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_IADD    = 4'd4,
    OP_ISUB    = 4'd5,
    OP_IMUL    = 4'd6,
    OP_IDIV    = 4'd7,
    OP_CMP     = 4'd8,
    OP_TOINT   = 4'd9,
    OP_FROMINT = 4'd10,
    OP_RESCALE = 4'd11,
    OP_HALF    = 4'd12,
    OP_DOUBLE  = 4'd13,
    OP_INC     = 4'd14,
    OP_DEC     = 4'd15
  } qfx_op_e;

  // Result fields and the final fix-up controls that ride alongside the divider.
  typedef struct packed {
    logic [63:0] result;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
    logic        is_div;
    logic        q_neg;
  } qfx_res_t;

  // Working state of one restoring division step.
  typedef struct packed {
    logic [63:0]  rem;
    logic [127:0] work;
    logic [63:0]  divisor;
  } qfx_div_t;

endpackage
`default_nettype wire

>>> design/q_format_fixed_point_alu.sv
// Path from input transfer to result: four front stages, 128 divider steps, output register.
// Throughput: one item per cycle; the 128 one-bit steps of the restoring divider set the depth.
// Every operation takes the same path, so results leave in input order.
// The pipeline holds only while the skid register is occupied; a result may wait meanwhile.
// Reset clears all valid bits and the output and skid flags; payload registers are not reset.
`default_nettype none
module q_format_fixed_point_alu #(
  parameter int unsigned FRACTION_BITS = qfx_pkg::DefFractionBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: operand_a [63:0], operand_b [127:64], int_operand [159:128],
  // source_frac_bits [165:160], zero fill [167:166].
  input  wire logic [167:0] s_axis_tdata,
  // tuser: opcode [3:0].
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: result_value [63:0], less_than [64], equal_to [65], greater_than [66],
  // divide_by_zero [67], zero fill [71:68].
  output logic [71:0]       m_axis_tdata
);

  localparam int unsigned Steps = qfx_pkg::DivSteps;

  logic              adv;
  logic              v   [0:Steps];
  qfx_pkg::qfx_res_t res [0:Steps];
  qfx_pkg::qfx_div_t dv  [0:Steps];
  logic [67:0]       out_data;

  // The whole pipeline moves together whenever the skid register is free.
  assign s_axis_tready = adv;

  qfx_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .valid_i           (s_axis_tvalid),
    .opcode_i          (s_axis_tuser),
    .operand_a_i       (s_axis_tdata[63:0]),
    .operand_b_i       (s_axis_tdata[127:64]),
    .int_operand_i     (s_axis_tdata[159:128]),
    .source_frac_bits_i(s_axis_tdata[165:160]),
    .valid_o           (v[0]),
    .res_o             (res[0]),
    .div_o             (dv[0])
  );

  // One quotient bit per stage; the low 64 bits of the work register end up holding the quotient.
  for (genvar g = 0; g < Steps; g++) begin : g_div
    qfx_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(v[g]),
      .res_i  (res[g]),
      .div_i  (dv[g]),
      .valid_o(v[g+1]),
      .res_o  (res[g+1]),
      .div_o  (dv[g+1])
    );
  end

  qfx_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v[Steps]),
    .res_i      (res[Steps]),
    .quot_i     (dv[Steps].work[63:0]),
    .adv_o      (adv),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  assign m_axis_tdata = {4'd0, out_data};

  // A blocked input side always means a finished result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled without a pending result");

  // At most one compare flag is set in a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[66:64]))
    else $error("more than one compare flag set");

  // A divide by zero returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[67]) |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("divide by zero with non-zero result");

endmodule
`default_nettype wire

>>> design/qfx_front.sv
// Front pipeline: operand decode, simple operations, rescale, multiplier and divider set-up.
`default_nettype none
module qfx_front #(
  parameter int unsigned FRACTION_BITS = qfx_pkg::DefFractionBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire logic [3:0]         opcode_i,
  input  wire logic [63:0]        operand_a_i,
  input  wire logic [63:0]        operand_b_i,
  input  wire logic [31:0]        int_operand_i,
  input  wire logic [5:0]         source_frac_bits_i,
  output logic                    valid_o,
  output qfx_pkg::qfx_res_t       res_o,
  output qfx_pkg::qfx_div_t       div_o
);

  localparam logic [6:0] FracW = 7'(FRACTION_BITS);

  // Stage A.
  qfx_pkg::qfx_op_e op;
  logic [63:0] ix, ishift, bm, dv, ma, md, simple, sar_a;
  logic        nd, dz, narrow;
  logic [6:0]  src_ext;
  logic [5:0]  sh;

  logic        va_q;
  qfx_pkg::qfx_op_e op_a_q;
  logic [63:0] a_a_q, bm_a_q, ll_a_q, lh_a_q, hl_a_q, hh_a_q, ma_a_q, md_a_q, res_a_q;
  logic        qn_a_q, dz_a_q, lt_a_q, eq_a_q, gt_a_q, nar_a_q;
  logic [5:0]  sh_a_q;

  always_comb begin
    op      = qfx_pkg::qfx_op_e'(opcode_i);
    ix      = {{32{int_operand_i[31]}}, int_operand_i};
    ishift  = ix << FRACTION_BITS;
    bm      = (op == qfx_pkg::OP_IMUL) ? ix : operand_b_i;
    dv      = (op == qfx_pkg::OP_DIV) ? operand_b_i : ix;
    nd      = dv[63];
    ma      = operand_a_i[63] ? (64'd0 - operand_a_i) : operand_a_i;
    md      = nd ? (64'd0 - dv) : dv;
    dz      = (dv == 64'd0) && ((op == qfx_pkg::OP_DIV) || (op == qfx_pkg::OP_IDIV));
    src_ext = {1'b0, source_frac_bits_i};
    narrow  = src_ext > FracW;
    sh      = narrow ? 6'(src_ext - FracW) : 6'(FracW - src_ext);
    sar_a   = 64'($signed(operand_a_i) >>> FRACTION_BITS);
    case (op)
      qfx_pkg::OP_ADD:     simple = operand_a_i + operand_b_i;
      qfx_pkg::OP_SUB:     simple = operand_a_i - operand_b_i;
      qfx_pkg::OP_IADD:    simple = operand_a_i + ishift;
      qfx_pkg::OP_ISUB:    simple = operand_a_i - ishift;
      qfx_pkg::OP_TOINT:   simple = {{32{sar_a[31]}}, sar_a[31:0]};
      qfx_pkg::OP_FROMINT: simple = ishift;
      qfx_pkg::OP_HALF:    simple = {operand_a_i[63], operand_a_i[63:1]};
      qfx_pkg::OP_DOUBLE:  simple = {operand_a_i[62:0], 1'b0};
      qfx_pkg::OP_INC:     simple = operand_a_i + 64'd1;
      qfx_pkg::OP_DEC:     simple = operand_a_i - 64'd1;
      default:             simple = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op_a_q  <= op;
      a_a_q   <= operand_a_i;
      bm_a_q  <= bm;
      ll_a_q  <= 64'(operand_a_i[31:0])  * 64'(bm[31:0]);
      lh_a_q  <= 64'(operand_a_i[31:0])  * 64'(bm[63:32]);
      hl_a_q  <= 64'(operand_a_i[63:32]) * 64'(bm[31:0]);
      hh_a_q  <= 64'(operand_a_i[63:32]) * 64'(bm[63:32]);
      ma_a_q  <= ma;
      md_a_q  <= md;
      qn_a_q  <= operand_a_i[63] ^ nd;
      dz_a_q  <= dz;
      res_a_q <= simple;
      lt_a_q  <= (op == qfx_pkg::OP_CMP) && ($signed(operand_a_i) < $signed(operand_b_i));
      eq_a_q  <= (op == qfx_pkg::OP_CMP) && (operand_a_i == operand_b_i);
      gt_a_q  <= (op == qfx_pkg::OP_CMP) && ($signed(operand_a_i) > $signed(operand_b_i));
      nar_a_q <= narrow;
      sh_a_q  <= sh;
    end
  end

  // Stage B: middle partial sum, rescale shift, dividend alignment.
  logic        vb_q;
  qfx_pkg::qfx_op_e op_b_q;
  logic [63:0] a_b_q, bm_b_q, ll_b_q, hh_b_q, md_b_q, res_b_q, resc_b_q;
  logic [64:0] mid_b_q;
  logic [127:0] dvd_b_q;
  logic        qn_b_q, dz_b_q, lt_b_q, eq_b_q, gt_b_q, rneg_b_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op_b_q   <= op_a_q;
      a_b_q    <= a_a_q;
      bm_b_q   <= bm_a_q;
      ll_b_q   <= ll_a_q;
      hh_b_q   <= hh_a_q;
      md_b_q   <= md_a_q;
      res_b_q  <= res_a_q;
      mid_b_q  <= {1'b0, lh_a_q} + {1'b0, hl_a_q};
      resc_b_q <= nar_a_q ? (ma_a_q >> sh_a_q) : (a_a_q << sh_a_q);
      dvd_b_q  <= (op_a_q == qfx_pkg::OP_DIV) ? ({64'd0, ma_a_q} << FRACTION_BITS)
                                              : {64'd0, ma_a_q};
      qn_b_q   <= qn_a_q;
      dz_b_q   <= dz_a_q;
      lt_b_q   <= lt_a_q;
      eq_b_q   <= eq_a_q;
      gt_b_q   <= gt_a_q;
      rneg_b_q <= nar_a_q && a_a_q[63];
    end
  end

  // Stage C: full unsigned product, rescale sign restore.
  logic        vc_q;
  qfx_pkg::qfx_op_e op_c_q;
  logic [63:0] a_c_q, bm_c_q, md_c_q, res_c_q;
  logic [127:0] prod_c_q, dvd_c_q;
  logic        qn_c_q, dz_c_q, lt_c_q, eq_c_q, gt_c_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op_c_q   <= op_b_q;
      a_c_q    <= a_b_q;
      bm_c_q   <= bm_b_q;
      md_c_q   <= md_b_q;
      prod_c_q <= {hh_b_q, ll_b_q} + ({63'd0, mid_b_q} << 32);
      dvd_c_q  <= dvd_b_q;
      if (op_b_q == qfx_pkg::OP_RESCALE) begin
        res_c_q <= rneg_b_q ? (64'd0 - resc_b_q) : resc_b_q;
      end else begin
        res_c_q <= res_b_q;
      end
      qn_c_q   <= qn_b_q;
      dz_c_q   <= dz_b_q;
      lt_c_q   <= lt_b_q;
      eq_c_q   <= eq_b_q;
      gt_c_q   <= gt_b_q;
    end
  end

  // Stage D: signed correction of the upper product half and result select.
  logic [63:0]  hi_fix;
  logic [127:0] full;

  always_comb begin
    hi_fix = prod_c_q[127:64] - (a_c_q[63] ? bm_c_q : 64'd0) - (bm_c_q[63] ? a_c_q : 64'd0);
    full   = {hi_fix, prod_c_q[63:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      case (op_c_q)
        qfx_pkg::OP_MUL:  res_o.result <= 64'(full >> FRACTION_BITS);
        qfx_pkg::OP_IMUL: res_o.result <= prod_c_q[63:0];
        default:          res_o.result <= res_c_q;
      endcase
      res_o.lt     <= lt_c_q;
      res_o.eq     <= eq_c_q;
      res_o.gt     <= gt_c_q;
      res_o.dz     <= dz_c_q;
      res_o.is_div <= (op_c_q == qfx_pkg::OP_DIV) || (op_c_q == qfx_pkg::OP_IDIV);
      res_o.q_neg  <= qn_c_q;
      div_o.rem     <= 64'd0;
      div_o.work    <= dvd_c_q;
      div_o.divisor <= md_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      va_q    <= valid_i;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      valid_o <= vc_q;
    end
  end

endmodule
`default_nettype wire

>>> design/qfx_div_step.sv
// One registered step of the restoring divider, with the result fields carried alongside.
`default_nettype none
module qfx_div_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire qfx_pkg::qfx_res_t  res_i,
  input  wire qfx_pkg::qfx_div_t  div_i,
  output logic                    valid_o,
  output qfx_pkg::qfx_res_t       res_o,
  output qfx_pkg::qfx_div_t       div_o
);

  logic [64:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {div_i.rem, div_i.work[127]};
    ge     = rem_sh >= {1'b0, div_i.divisor};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o         <= res_i;
      div_o.divisor <= div_i.divisor;
      div_o.work    <= {div_i.work[126:0], ge};
      div_o.rem     <= ge ? 64'(rem_sh - {1'b0, div_i.divisor}) : rem_sh[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

endmodule
`default_nettype wire

>>> design/qfx_out.sv
// Final quotient sign fix-up, output register and skid register.
`default_nettype none
module qfx_out (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire qfx_pkg::qfx_res_t  res_i,
  input  wire logic [63:0]        quot_i,
  output logic                    adv_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [67:0]             out_data_o
);

  logic [67:0] fin, skid_q;
  logic [63:0] value;
  logic        skid_v_q;

  always_comb begin
    if (res_i.is_div) begin
      value = res_i.dz ? 64'd0 : (res_i.q_neg ? (64'd0 - quot_i) : quot_i);
    end else begin
      value = res_i.result;
    end
    fin   = {res_i.dz, res_i.gt, res_i.eq, res_i.lt, value};
    adv_o = !skid_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (adv_o && valid_i) begin
      if (!out_valid_o || out_ready_i) begin
        out_valid_o <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_valid_o && out_ready_i) begin
      out_valid_o <= skid_v_q;
      skid_v_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      if (!out_valid_o || out_ready_i) begin
        out_data_o <= fin;
      end else begin
        skid_q <= fin;
      end
    end else if (out_valid_o && out_ready_i && skid_v_q) begin
      out_data_o <= skid_q;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the fixed-point ALU: directed table and random streams.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qfx_pkg::*;

  localparam int unsigned FB = qfx_pkg::DefFractionBits;
  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q = 64'h1 << FB;
  // Cycles without any transfer on either side before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // Covers the pipeline depth of the ALU, with margin for the drain at the end.
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    qfx_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] iv;
    logic [5:0]  src;
  } alu_item_t;

  typedef struct {
    logic [63:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
  } alu_result_t;

  typedef struct {
    alu_item_t   item;
    bit          known;
    alu_result_t res;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  // Idling odds in percent, changed from phase to phase.
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  alu_result_t pending_results[$];

  q_format_fixed_point_alu u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Computes the result the ALU should give for one operation.
  function automatic alu_result_t alu_predict(alu_item_t it);
    alu_result_t r;
    logic [63:0] ix;
    logic [63:0] ishift;
    logic [63:0] ma;
    logic [63:0] mb;
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    logic [127:0] num;
    logic [127:0] quo;
    int unsigned shift_amt;
    r = '{value: '0, lt: 1'b0, eq: 1'b0, gt: 1'b0, dz: 1'b0};
    ix = {{32{it.iv[31]}}, it.iv};
    ishift = ix << FB;
    ma = it.a[63] ? -it.a : it.a;
    case (it.op)
      OP_ADD:  r.value = it.a + it.b;
      OP_SUB:  r.value = it.a - it.b;
      OP_MUL: begin
        wa = {{64{it.a[63]}}, it.a};
        wb = {{64{it.b[63]}}, it.b};
        prod = wa * wb;
        r.value = prod[FB+63:FB];
      end
      OP_DIV: begin
        if (it.b == '0) begin
          r.dz = 1'b1;
        end else begin
          // The dividend is widened before the shift, so nothing is lost at the top.
          mb = it.b[63] ? -it.b : it.b;
          num = {64'b0, ma} << FB;
          quo = num / {64'b0, mb};
          r.value = (it.a[63] != it.b[63]) ? -quo[63:0] : quo[63:0];
        end
      end
      OP_IADD: r.value = it.a + ishift;
      OP_ISUB: r.value = it.a - ishift;
      OP_IMUL: r.value = it.a * ix;
      OP_IDIV: begin
        if (ix == '0) begin
          r.dz = 1'b1;
        end else begin
          mb = ix[63] ? -ix : ix;
          r.value = (it.a[63] != ix[63]) ? -(ma / mb) : (ma / mb);
        end
      end
      OP_CMP: begin
        r.lt = $signed(it.a) < $signed(it.b);
        r.eq = it.a == it.b;
        r.gt = $signed(it.a) > $signed(it.b);
      end
      OP_TOINT: begin
        ma = $signed(it.a) >>> FB;
        r.value = {{32{ma[31]}}, ma[31:0]};
      end
      OP_FROMINT: r.value = ishift;
      OP_RESCALE: begin
        if (it.src > FB) begin
          // Narrowing works on the magnitude, so it rounds toward zero.
          shift_amt = it.src - FB;
          r.value = it.a[63] ? -(ma >> shift_amt) : (ma >> shift_amt);
        end else begin
          r.value = it.a << (FB - it.src);
        end
      end
      OP_HALF:   r.value = $signed(it.a) >>> 1;
      OP_DOUBLE: r.value = it.a << 1;
      OP_INC:    r.value = it.a + 64'd1;
      default:   r.value = it.a - 64'd1;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Picks operand values that favour extremes, Q-format ones and small numbers.
  function automatic logic [63:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return MIN_V;
      1:       return MAX_V;
      2:       return '0;
      3:       return ONE_Q * 64'($signed($urandom_range(0, 16)) - 8);
      4:       return 64'($signed($urandom_range(0, 2000)) - 1000);
      5:       return {{24{1'b0}}, 40'({$urandom, $urandom})} ^ {64{$urandom_range(0, 1) == 1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_int();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Drives one item from a rising edge and returns at the edge where it transfers.
  task automatic send_item(alu_item_t it, bit known, alu_result_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {2'b00, it.src, it.iv, it.b, it.a};
    do @(negedge clk_i); while (!s_axis_tready);
    pending_results.push_back(known ? want : alu_predict(it));
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // The receiver stalls at random; the odds follow the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Values are sampled at the falling edge, before the transfer edge.
  always @(negedge clk_i) begin
    alu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result transfer with nothing expected: %h", $realtime, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== want.value)
          report_mismatch("result_value", m_axis_tdata[63:0], want.value);
        if (m_axis_tdata[64] !== want.lt)
          report_mismatch("less_than", 64'(m_axis_tdata[64]), 64'(want.lt));
        if (m_axis_tdata[65] !== want.eq)
          report_mismatch("equal_to", 64'(m_axis_tdata[65]), 64'(want.eq));
        if (m_axis_tdata[66] !== want.gt)
          report_mismatch("greater_than", 64'(m_axis_tdata[66]), 64'(want.gt));
        if (m_axis_tdata[67] !== want.dz)
          report_mismatch("divide_by_zero", 64'(m_axis_tdata[67]), 64'(want.dz));
      end
    end
  end

  // Watchdog: counts cycles in which neither side completes a transfer.
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("q_format_fixed_point_alu regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed rows: expectations are written in only where they are obvious.
  dir_row_t dir_rows [23] = '{
    '{'{OP_ADD, 64'd0, 64'd0, 32'd0, 6'd0}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADD, MAX_V, 64'd1, 32'd0, 6'd0}, 1'b1, '{MIN_V, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_SUB, MIN_V, 64'd1, 32'd0, 6'd0}, 1'b1, '{MAX_V, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_MUL, ONE_Q, -(ONE_Q * 3 / 2), 32'd0, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_MUL, MIN_V, MIN_V, 32'd0, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_DIV, ONE_Q * 3, 64'd0, 32'd0, 6'd0}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{OP_DIV, -(ONE_Q * 7), ONE_Q * 2, 32'd0, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_DIV, MIN_V, 64'd1, 32'd0, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_IADD, 64'd5, 64'd0, 32'hFFFF_FFFF, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ISUB, MIN_V, 64'd0, 32'h7FFF_FFFF, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_IMUL, MAX_V, 64'd0, 32'h8000_0000, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_IDIV, MIN_V, 64'd0, 32'hFFFF_FFFF, 6'd0}, 1'b1, '{MIN_V, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_IDIV, 64'd5, 64'd0, 32'd0, 6'd0}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{OP_CMP, MIN_V, MAX_V, 32'd0, 6'd0}, 1'b1, '{64'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{OP_CMP, 64'd5, 64'd5, 32'd0, 6'd0}, 1'b1, '{64'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{OP_CMP, MAX_V, MIN_V, 32'd0, 6'd0}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{OP_TOINT, MAX_V, 64'd0, 32'd0, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_FROMINT, 64'd0, 64'd0, 32'h8000_0000, 6'd0}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_RESCALE, MIN_V, 64'd0, 32'd0, 6'd63}, 1'b0, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_RESCALE, 64'd1, 64'd0, 32'd0, 6'd0}, 1'b1, '{ONE_Q, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_HALF, {64{1'b1}}, 64'd0, 32'd0, 6'd0}, 1'b1, '{{64{1'b1}}, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_DOUBLE, MIN_V, 64'd0, 32'd0, 6'd0}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_INC, MAX_V, 64'd0, 32'd0, 6'd0}, 1'b1, '{MIN_V, 1'b0, 1'b0, 1'b0, 1'b0}}
  };

  initial begin
    alu_item_t it;
    alu_result_t none;
    none = '{value: '0, lt: 1'b0, eq: 1'b0, gt: 1'b0, dz: 1'b0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].res);
    // The sender holds off here until every directed result has come back.
    wait_drained();
    @(posedge clk_i);

    // Random phases: free flow, sparse sender, stalling receiver, then both.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 26 : 0;
      sink_stall_pct  = (phase == 2) ? 88 : (phase == 3) ? 26 : 0;
      for (int n = 0; n < 475; n++) begin
        it.op  = qfx_op_e'($urandom_range(0, 15));
        it.a   = pick_raw();
        it.b   = pick_raw();
        it.iv  = pick_int();
        it.src = 6'($urandom_range(0, 63));
        send_item(it, 1'b0, none);
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("q_format_fixed_point_alu regression: pass");
    end else begin
      $display("q_format_fixed_point_alu regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
